[rtl/core/mch_pkg.sv]
package mch_pkg;

  localparam int CORDIC_STAGES = 16;

  localparam int WORD_W     = 16;
  localparam int HALL_W     = 8;
  localparam int HEAD_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam int AXIS_W   = 13;
  localparam int TX_W     = 14;
  localparam int OFFP_W   = 17;
  localparam int NUM_W    = 23;
  localparam int SH_W     = 5;
  localparam int XW       = 34;
  localparam int ZW       = 25;
  localparam int NORM_MSB = 29;
  localparam int RND_SH   = 8;

  localparam logic [AXIS_W-1:0]    OVF_MARK   = 13'h1000;
  localparam logic [1:0]           HALL_OK    = 2'b01;
  localparam logic [ZW-1:0]        ANGLE_180  = 25'd2949120;
  localparam logic [ZW-1:0]        ANGLE_360  = 25'd5898240;
  localparam logic [ZW-1:0]        ROUND_HALF = 25'd128;
  localparam logic [HEAD_W-1:0]    HEAD_FULL  = 15'd23040;
  localparam logic [CFG_DATA_W-1:0] GAIN_ZERO = 8'h00;
  localparam logic [CFG_DATA_W-1:0] GAIN_MIN  = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X      = 3'd0,
    REG_OFFSET_Y      = 3'd1,
    REG_GAIN_X        = 3'd2,
    REG_GAIN_Y        = 3'd3,
    REG_COMMON_GAIN   = 3'd4,
    REG_COMMON_OFFSET = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
    logic [7:0]        gain_x;
    logic [7:0]        gain_y;
    logic [7:0]        divisor;
    logic              gains_off;
    logic [6:0]        common_offset;
  } mch_cfg_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [ZW-1:0]        z;
    logic                 force_zero;
    logic                 hall_ok;
  } mch_rot_t;

  typedef struct packed {
    logic [HEAD_W-1:0] heading_angle;
    logic              heading_valid;
  } mch_res_t;

  function automatic logic [ZW-1:0] atan_angle(input logic [4:0] idx);
    logic [ZW-1:0] a;
    case (idx)
      5'd0:    a = 25'd737280;
      5'd1:    a = 25'd435242;
      5'd2:    a = 25'd229970;
      5'd3:    a = 25'd116736;
      5'd4:    a = 25'd58595;
      5'd5:    a = 25'd29326;
      5'd6:    a = 25'd14667;
      5'd7:    a = 25'd7334;
      5'd8:    a = 25'd3667;
      5'd9:    a = 25'd1833;
      5'd10:   a = 25'd917;
      5'd11:   a = 25'd458;
      5'd12:   a = 25'd229;
      5'd13:   a = 25'd115;
      5'd14:   a = 25'd57;
      5'd15:   a = 25'd29;
      5'd16:   a = 25'd14;
      5'd17:   a = 25'd7;
      5'd18:   a = 25'd4;
      5'd19:   a = 25'd2;
      5'd20:   a = 25'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[rtl/core/mch_if.sv]
interface mch_in_if;
  logic                        valid;
  logic                        ready;
  logic [mch_pkg::WORD_W-1:0]  x_data_word;
  logic [mch_pkg::WORD_W-1:0]  y_data_word;
  logic [mch_pkg::HALL_W-1:0]  hall_status_byte;

  modport source (output valid, output x_data_word, output y_data_word,
                  output hall_status_byte, input ready);
  modport sink   (input valid, input x_data_word, input y_data_word,
                  input hall_status_byte, output ready);
endinterface

interface mch_out_if;
  logic                        valid;
  logic                        ready;
  logic [mch_pkg::HEAD_W-1:0]  heading_angle;
  logic                        heading_valid;

  modport source (output valid, output heading_angle, output heading_valid, input ready);
  modport sink   (input valid, input heading_angle, input heading_valid, output ready);
endinterface

interface mch_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mch_pkg::CFG_IDX_W-1:0]   index;
  logic [mch_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/mch_cfg_regs.sv]
module mch_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  mch_cfg_if.sink           cfg_bus,
  output mch_pkg::mch_cfg_t cfg
);
  import mch_pkg::*;

  logic [7:0] offset_x_r;
  logic [7:0] offset_y_r;
  logic [7:0] gain_x_r;
  logic [7:0] gain_y_r;
  logic [7:0] common_gain_r;
  logic [6:0] common_offset_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r      <= '0;
      offset_y_r      <= '0;
      gain_x_r        <= '0;
      gain_y_r        <= '0;
      common_gain_r   <= '0;
      common_offset_r <= '0;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_idx_t'(cfg_bus.index))
        REG_OFFSET_X:      offset_x_r      <= cfg_bus.data;
        REG_OFFSET_Y:      offset_y_r      <= cfg_bus.data;
        REG_GAIN_X:        gain_x_r        <= cfg_bus.data;
        REG_GAIN_Y:        gain_y_r        <= cfg_bus.data;
        REG_COMMON_GAIN:   common_gain_r   <= cfg_bus.data;
        REG_COMMON_OFFSET: common_offset_r <= cfg_bus.data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.offset_x      = offset_x_r;
    cfg.offset_y      = offset_y_r;
    cfg.gain_x        = {~gain_x_r[7], gain_x_r[6:0]};
    cfg.gain_y        = {~gain_y_r[7], gain_y_r[6:0]};
    cfg.divisor       = {~common_gain_r[7], common_gain_r[6:0]};
    cfg.gains_off     = (common_gain_r == GAIN_ZERO) || (common_gain_r == GAIN_MIN);
    cfg.common_offset = common_offset_r;
  end

endmodule

[rtl/core/mch_front.sv]
module mch_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  mch_pkg::mch_cfg_t cfg,
  mch_in_if.sink            in_bus,
  output logic              norm_valid,
  output mch_pkg::mch_rot_t norm
);
  import mch_pkg::*;

  logic [AXIS_W-1:0]        ax_raw;
  logic [AXIS_W-1:0]        ay_raw;
  logic signed [TX_W-1:0]   s1_tx_nxt;
  logic signed [TX_W-1:0]   s1_ty_nxt;
  logic signed [OFFP_W-1:0] s1_ox_nxt;
  logic signed [OFFP_W-1:0] s1_oy_nxt;

  logic                     s1_valid_r;
  logic                     s1_hall_r;
  logic signed [TX_W-1:0]   s1_tx_r;
  logic signed [TX_W-1:0]   s1_ty_r;
  logic signed [OFFP_W-1:0] s1_ox_r;
  logic signed [OFFP_W-1:0] s1_oy_r;

  logic signed [NUM_W-1:0]  s2_nx_nxt;
  logic signed [NUM_W-1:0]  s2_ny_nxt;
  logic                     s2_valid_r;
  logic                     s2_hall_r;
  logic signed [NUM_W-1:0]  s2_nx_r;
  logic signed [NUM_W-1:0]  s2_ny_r;

  logic [NUM_W-1:0]         mag_x;
  logic [NUM_W-1:0]         mag_y;
  logic [NUM_W-1:0]         mag_or;
  logic [SH_W-1:0]          msb_pos;
  logic [SH_W-1:0]          s3_sh_nxt;
  logic                     s3_valid_r;
  logic                     s3_hall_r;
  logic                     s3_zero_r;
  logic [SH_W-1:0]          s3_sh_r;
  logic signed [NUM_W-1:0]  s3_nx_r;
  logic signed [NUM_W-1:0]  s3_ny_r;

  logic signed [XW-1:0]     sx;
  logic signed [XW-1:0]     sy;
  mch_rot_t                 s4_nxt;
  logic                     s4_valid_r;
  mch_rot_t                 s4_r;

  assign in_bus.ready = en;

  always_comb begin
    ax_raw    = in_bus.x_data_word[WORD_W-1:WORD_W-AXIS_W];
    ay_raw    = in_bus.y_data_word[WORD_W-1:WORD_W-AXIS_W];
    s1_tx_nxt = {ax_raw[AXIS_W-1], ax_raw}
              + ((ax_raw == OVF_MARK) ? '0 : {{(TX_W-7){1'b0}}, cfg.common_offset});
    s1_ty_nxt = {ay_raw[AXIS_W-1], ay_raw}
              + ((ay_raw == OVF_MARK) ? '0 : {{(TX_W-7){1'b0}}, cfg.common_offset});
    s1_ox_nxt = cfg.offset_x * $signed({1'b0, cfg.divisor});
    s1_oy_nxt = cfg.offset_y * $signed({1'b0, cfg.divisor});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hall_r <= (in_bus.hall_status_byte[7:6] == HALL_OK);
      s1_tx_r   <= s1_tx_nxt;
      s1_ty_r   <= s1_ty_nxt;
      s1_ox_r   <= s1_ox_nxt;
      s1_oy_r   <= s1_oy_nxt;
    end
  end

  always_comb begin
    if (cfg.gains_off) begin
      s2_nx_nxt = NUM_W'(cfg.offset_x) <<< 5;
      s2_ny_nxt = NUM_W'(cfg.offset_y) <<< 5;
    end else begin
      s2_nx_nxt = s1_tx_r * $signed({1'b0, cfg.gain_x}) + (NUM_W'(s1_ox_r) <<< 5);
      s2_ny_nxt = s1_ty_r * $signed({1'b0, cfg.gain_y}) + (NUM_W'(s1_oy_r) <<< 5);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_hall_r <= s1_hall_r;
      s2_nx_r   <= s2_nx_nxt;
      s2_ny_r   <= s2_ny_nxt;
    end
  end

  always_comb begin
    mag_x   = s2_nx_r[NUM_W-1] ? -s2_nx_r : s2_nx_r;
    mag_y   = s2_ny_r[NUM_W-1] ? -s2_ny_r : s2_ny_r;
    mag_or  = mag_x | mag_y;
    msb_pos = '0;
    for (int i = 0; i < NUM_W; i++) begin
      if (mag_or[i]) begin
        msb_pos = SH_W'(i);
      end
    end
    s3_sh_nxt = SH_W'(NORM_MSB) - msb_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_hall_r <= s2_hall_r;
      s3_zero_r <= (mag_or == '0);
      s3_sh_r   <= s3_sh_nxt;
      s3_nx_r   <= s2_nx_r;
      s3_ny_r   <= s2_ny_r;
    end
  end

  always_comb begin
    sx = XW'(s3_nx_r) <<< s3_sh_r;
    sy = XW'(s3_ny_r) <<< s3_sh_r;
    s4_nxt.force_zero = s3_zero_r || !s3_hall_r;
    s4_nxt.hall_ok    = s3_hall_r;
    if (sx[XW-1]) begin
      s4_nxt.x = -sx;
      s4_nxt.y = -sy;
      s4_nxt.z = ANGLE_180;
    end else begin
      s4_nxt.x = sx;
      s4_nxt.y = sy;
      s4_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= s4_nxt;
    end
  end

  assign norm_valid = s4_valid_r;
  assign norm       = s4_r;

endmodule

[rtl/core/mch_cordic.sv]
module mch_cordic (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  mch_pkg::mch_rot_t in_rot,
  output logic              out_valid,
  output mch_pkg::mch_rot_t out_rot
);
  import mch_pkg::*;

  mch_rot_t stage_r [CORDIC_STAGES];
  logic     valid_r [CORDIC_STAGES];
  mch_rot_t src     [CORDIC_STAGES+1];
  logic     vsrc    [CORDIC_STAGES+1];

  assign src[0]  = in_rot;
  assign vsrc[0] = in_valid;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic [ZW-1:0]        za;
    mch_rot_t             rot_nxt;

    always_comb begin
      xs      = src[g].x >>> g;
      ys      = src[g].y >>> g;
      za      = atan_angle(5'(g));
      rot_nxt = src[g];
      if (!src[g].y[XW-1] && (src[g].y != '0)) begin
        rot_nxt.x = src[g].x + ys;
        rot_nxt.y = src[g].y - xs;
        rot_nxt.z = src[g].z + za;
      end else begin
        rot_nxt.x = src[g].x - ys;
        rot_nxt.y = src[g].y + xs;
        rot_nxt.z = src[g].z - za;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (en) begin
        valid_r[g] <= vsrc[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r[g] <= rot_nxt;
      end
    end

    assign src[g+1]  = stage_r[g];
    assign vsrc[g+1] = valid_r[g];
  end

  assign out_valid = vsrc[CORDIC_STAGES];
  assign out_rot   = src[CORDIC_STAGES];

endmodule

[rtl/core/mch_out.sv]
module mch_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  mch_pkg::mch_rot_t rot,
  output logic              en,
  mch_out_if.source         out_bus
);
  import mch_pkg::*;

  logic [ZW-1:0] z_wrap;
  logic [ZW-1:0] z_rnd;
  logic [HEAD_W-1:0] head;
  mch_res_t      res;
  logic          take;
  logic          fire;

  logic          out_valid_r;
  logic          skid_valid_r;
  mch_res_t      out_r;
  mch_res_t      skid_r;

  always_comb begin
    z_wrap = rot.z[ZW-1] ? rot.z + ANGLE_360 : rot.z;
    z_rnd  = z_wrap + ROUND_HALF;
    head   = z_rnd[HEAD_W+RND_SH-1:RND_SH];
    if (rot.force_zero || (head >= HEAD_FULL)) begin
      res.heading_angle = '0;
    end else begin
      res.heading_angle = head;
    end
    res.heading_valid = rot.hall_ok;
  end

  assign en   = !skid_valid_r;
  assign take = en && in_valid;
  assign fire = out_valid_r && out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (take) begin
      if (!out_valid_r || fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (fire) begin
        out_r <= skid_r;
      end
    end else if (take) begin
      if (!out_valid_r || fire) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.heading_angle = out_r.heading_angle;
  assign out_bus.heading_valid = out_r.heading_valid;

endmodule

[rtl/core/magnetometer_compass_heading_core.sv]
// Compass heading from the X and Y magnetometer data words: each beat on
// in_bus yields one beat on out_bus with the heading in 1/64 degree (0 north,
// 90 east) and a valid flag taken from hall status bits 7..6 (a heading of 0
// when they are not 01). The block takes one beat per clock while in_bus.ready
// is high. Its pipeline holds four front stages (trim and offset, gain
// multiply, magnitude scan, normalize and half-turn fold), one stage per
// CORDIC iteration (CORDIC_STAGES, 16 by default), and the output register. When
// out_bus stalls, one beat lands in a skid register and in_bus.ready drops
// for as long as that register is full. cfg_bus is always ready; write the
// trim registers only while no beat is in flight.
module magnetometer_compass_heading_core (
  input  logic     clk,
  input  logic     rst_n,
  mch_in_if.sink   in_bus,
  mch_out_if.source out_bus,
  mch_cfg_if.sink  cfg_bus
);
  import mch_pkg::*;

  mch_cfg_t cfg;
  logic     en;
  logic     norm_valid;
  mch_rot_t norm;
  logic     rot_valid;
  mch_rot_t rot;

  mch_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  mch_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .cfg        (cfg),
    .in_bus     (in_bus),
    .norm_valid (norm_valid),
    .norm       (norm)
  );

  mch_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (norm_valid),
    .in_rot    (norm),
    .out_valid (rot_valid),
    .out_rot   (rot)
  );

  mch_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rot_valid),
    .rot      (rot),
    .en       (en),
    .out_bus  (out_bus)
  );

endmodule
